### rtl/sset_pkg.sv
// shared types and constants of the sorted sparse entry table
package sset_pkg;

  // default sizing
  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned INDEX_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned COUNT_OUT_W = 9;

  // leaves per first-level group of the read-out tree
  localparam int unsigned GROUP_SIZE = 16;

  // result status codes
  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DELETED  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_FULL     = 3'd4,
    ST_GET      = 3'd5
  } status_e;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_NONE,
    OP_UPDATE,
    OP_INSERT,
    OP_DELETE
  } cell_op_e;

  // compare flags that one cell holds against the request key
  typedef struct packed {
    logic valid;
    logic eq;
    logic gt;
  } cell_flags_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic compare;
    logic execute;
    logic read;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_get;
  } dp_stat_t;

endpackage

### rtl/sorted_sparse_entry_table.sv
// top level of the sorted sparse entry table
//
// Keeps up to CAPACITY nonzero (row, column, value) entries sorted by row and
// then column in a chain of cells that all compare against the request key at
// once and shift by one place on insert or delete. A transaction is taken when
// start is high and busy is low. A set transaction passes through the compare
// and execute steps before its result shows, a get also through the two-level
// read-out tree; busy is high until the result is formed, so the next
// transaction can be taken in the cycle the result shows.
// result_valid_o is high for exactly one cycle per transaction and the
// receiver cannot stall it, so results must be taken when shown. No clearing
// pass is needed after reset: the entry count alone marks which cells hold data.
module sorted_sparse_entry_table #(
  parameter int unsigned CAPACITY   = sset_pkg::CAPACITY_DEF,
  parameter int unsigned INDEX_BITS = sset_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind_i,
  input  logic [sset_pkg::COORD_W-1:0]     row_index_i,
  input  logic [sset_pkg::COORD_W-1:0]     col_index_i,
  input  logic [sset_pkg::VALUE_W-1:0]     entry_value_i,
  output logic                             result_valid_o,
  output logic [sset_pkg::VALUE_W-1:0]     read_value_o,
  output logic [2:0]                       status_o,
  output logic [sset_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  sset_pkg::dp_cmd_t  cmd;
  sset_pkg::dp_stat_t stat;

  // sequencer
  sset_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // cell chain and result logic
  sset_datapath #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .entry_value_i  (entry_value_i),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

### rtl/sset_cell.sv
// one table cell: stored entry, key compare and neighbor shift
module sset_cell #(
  parameter int unsigned KW       = sset_pkg::INDEX_BITS_DEF,
  parameter bit          IS_FIRST = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmp_en_i,
  input  logic                         apply_en_i,
  input  sset_pkg::cell_op_e           op_i,
  input  logic [KW-1:0]                key_row_i,
  input  logic [KW-1:0]                key_col_i,
  input  logic [sset_pkg::VALUE_W-1:0] new_value_i,
  input  logic                         valid_i,
  input  logic [KW-1:0]                prev_row_i,
  input  logic [KW-1:0]                prev_col_i,
  input  logic [sset_pkg::VALUE_W-1:0] prev_value_i,
  input  sset_pkg::cell_flags_t        prev_flags_i,
  input  logic [KW-1:0]                next_row_i,
  input  logic [KW-1:0]                next_col_i,
  input  logic [sset_pkg::VALUE_W-1:0] next_value_i,
  output logic [KW-1:0]                row_o,
  output logic [KW-1:0]                col_o,
  output logic [sset_pkg::VALUE_W-1:0] value_o,
  output sset_pkg::cell_flags_t        flags_o
);

  logic [KW-1:0]                row_q, col_q;
  logic [sset_pkg::VALUE_W-1:0] value_q;
  sset_pkg::cell_flags_t        flags_q;
  logic                         take_prev, take_new, take_next, take_value;

  // compare stored key with the request key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cmp_en_i) begin
      flags_q.valid <= valid_i;
      flags_q.eq    <= valid_i && (row_q == key_row_i) && (col_q == key_col_i);
      flags_q.gt    <= valid_i && ({row_q, col_q} > {key_row_i, key_col_i});
    end
  end

  // local shift decisions
  always_comb begin
    take_prev  = 1'b0;
    take_new   = 1'b0;
    take_next  = 1'b0;
    take_value = 1'b0;
    unique case (op_i)
      sset_pkg::OP_UPDATE: take_value = flags_q.eq;
      sset_pkg::OP_INSERT: begin
        // cells past the insert point move up, the insert point takes the key
        take_prev = !IS_FIRST && prev_flags_i.gt;
        take_new  = (IS_FIRST || (prev_flags_i.valid && !prev_flags_i.gt)) &&
                    (!flags_q.valid || flags_q.gt);
      end
      sset_pkg::OP_DELETE: take_next = flags_q.eq || flags_q.gt;
      default: ;
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (apply_en_i) begin
      if (take_prev) begin
        row_q   <= prev_row_i;
        col_q   <= prev_col_i;
        value_q <= prev_value_i;
      end else if (take_new) begin
        row_q   <= key_row_i;
        col_q   <= key_col_i;
        value_q <= new_value_i;
      end else if (take_next) begin
        row_q   <= next_row_i;
        col_q   <= next_col_i;
        value_q <= next_value_i;
      end else if (take_value) begin
        value_q <= new_value_i;
      end
    end
  end

  assign row_o   = row_q;
  assign col_o   = col_q;
  assign value_o = value_q;
  assign flags_o = flags_q;

endmodule

### rtl/sset_datapath.sv
// datapath: request registers, cell chain, entry count, read-out tree, result
module sset_datapath #(
  parameter int unsigned CAPACITY   = sset_pkg::CAPACITY_DEF,
  parameter int unsigned INDEX_BITS = sset_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sset_pkg::dp_cmd_t                cmd_i,
  output sset_pkg::dp_stat_t               stat_o,
  input  logic                             kind_i,
  input  logic [sset_pkg::COORD_W-1:0]     row_index_i,
  input  logic [sset_pkg::COORD_W-1:0]     col_index_i,
  input  logic [sset_pkg::VALUE_W-1:0]     entry_value_i,
  output logic                             result_valid_o,
  output logic [sset_pkg::VALUE_W-1:0]     read_value_o,
  output logic [2:0]                       status_o,
  output logic [sset_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned KW    = INDEX_BITS;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned VW    = sset_pkg::VALUE_W;
  localparam int unsigned GRP   = sset_pkg::GROUP_SIZE;
  localparam int unsigned NGRP  = (CAPACITY + GRP - 1) / GRP;
  localparam int unsigned PADN  = NGRP * GRP;

  // request registers
  logic          req_get_q;
  logic [KW-1:0] key_row_q, key_col_q;
  logic [VW-1:0] req_value_q;

  // cell chain signals
  logic [KW-1:0]         row_a   [CAPACITY];
  logic [KW-1:0]         col_a   [CAPACITY];
  logic [VW-1:0]         value_a [CAPACITY];
  sset_pkg::cell_flags_t flags_a [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid;
  logic [PADN-1:0]       eq_pad;
  logic [VW-1:0]         value_pad [PADN];

  logic [CW-1:0]       count_q;
  logic                hit, full, zero_val;
  sset_pkg::cell_op_e  op;
  sset_pkg::status_e   status_d;
  sset_pkg::status_e   status_q;
  logic [VW-1:0]       group_d [NGRP];
  logic [VW-1:0]       group_q [NGRP];
  logic [VW-1:0]       read_d;
  logic [VW-1:0]       read_value_q;
  logic                result_valid_q;

  // capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_get_q   <= kind_i;
      key_row_q   <= KW'(row_index_i);
      key_col_q   <= KW'(col_index_i);
      req_value_q <= entry_value_i;
    end
  end

  // chain of cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int unsigned PREV = (k == 0) ? 0 : k - 1;
    localparam int unsigned NEXT = (k == CAPACITY - 1) ? k : k + 1;
    sset_pkg::cell_flags_t prev_flags;

    assign cell_valid[k] = (CW'(k) < count_q);
    assign prev_flags    = (k == 0) ? sset_pkg::cell_flags_t'('0) : flags_a[PREV];

    sset_cell #(
      .KW       (KW),
      .IS_FIRST (k == 0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmp_en_i     (cmd_i.compare),
      .apply_en_i   (cmd_i.execute),
      .op_i         (op),
      .key_row_i    (key_row_q),
      .key_col_i    (key_col_q),
      .new_value_i  (req_value_q),
      .valid_i      (cell_valid[k]),
      .prev_row_i   (row_a[PREV]),
      .prev_col_i   (col_a[PREV]),
      .prev_value_i (value_a[PREV]),
      .prev_flags_i (prev_flags),
      .next_row_i   (row_a[NEXT]),
      .next_col_i   (col_a[NEXT]),
      .next_value_i (value_a[NEXT]),
      .row_o        (row_a[k]),
      .col_o        (col_a[k]),
      .value_o      (value_a[k]),
      .flags_o      (flags_a[k])
    );

    assign eq_pad[k]    = flags_a[k].eq;
    assign value_pad[k] = value_a[k];
  end

  // padding leaves of the read-out tree
  for (genvar p = CAPACITY; p < PADN; p++) begin : g_pad
    assign eq_pad[p]    = 1'b0;
    assign value_pad[p] = '0;
  end

  // operation decision
  assign hit      = |eq_pad;
  assign full     = (count_q == CW'(CAPACITY));
  assign zero_val = (req_value_q[VW-2:0] == '0);

  always_comb begin
    priority if (req_get_q) begin
      op       = sset_pkg::OP_NONE;
      status_d = sset_pkg::ST_GET;
    end else if (zero_val && hit) begin
      op       = sset_pkg::OP_DELETE;
      status_d = sset_pkg::ST_DELETED;
    end else if (zero_val) begin
      op       = sset_pkg::OP_NONE;
      status_d = sset_pkg::ST_ABSENT;
    end else if (hit) begin
      op       = sset_pkg::OP_UPDATE;
      status_d = sset_pkg::ST_UPDATED;
    end else if (full) begin
      op       = sset_pkg::OP_NONE;
      status_d = sset_pkg::ST_FULL;
    end else begin
      op       = sset_pkg::OP_INSERT;
      status_d = sset_pkg::ST_INSERTED;
    end
  end

  // first level of the read-out tree: one group of cells each
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      group_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (eq_pad[g * GRP + j]) begin
          group_d[g] = group_d[g] | value_pad[g * GRP + j];
        end
      end
    end
  end

  // second level of the read-out tree
  always_comb begin
    read_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      read_d = read_d | group_q[g];
    end
  end

  // entry count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= (cmd_i.execute && !req_get_q) || cmd_i.read;
      if (cmd_i.execute) begin
        unique case (op)
          sset_pkg::OP_INSERT: count_q <= count_q + CW'(1);
          sset_pkg::OP_DELETE: count_q <= count_q - CW'(1);
          default: ;
        endcase
      end
    end
  end

  // result payload and tree registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (req_get_q) begin
        group_q <= group_d;
      end else begin
        read_value_q <= '0;
        status_q     <= status_d;
      end
    end
    if (cmd_i.read) begin
      read_value_q <= read_d;
      status_q     <= sset_pkg::ST_GET;
    end
  end

  assign stat_o.is_get  = req_get_q;
  assign result_valid_o = result_valid_q;
  assign read_value_o   = read_value_q;
  assign status_o       = status_q;
  assign entry_count_o  = sset_pkg::COUNT_OUT_W'(count_q);

endmodule

### rtl/sset_ctrl.sv
// controller: sequences compare, execute and read-out of one transaction
module sset_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sset_pkg::dp_stat_t stat_i,
  output sset_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_READ
  } state_e;

  state_e state_q;
  logic   compare_q, execute_q, read_q;

  // state and registered commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      compare_q <= 1'b0;
      execute_q <= 1'b0;
      read_q    <= 1'b0;
    end else begin
      compare_q <= 1'b0;
      execute_q <= 1'b0;
      read_q    <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q   <= S_CMP;
            compare_q <= 1'b1;
          end
        end
        S_CMP: begin
          state_q   <= S_EXEC;
          execute_q <= 1'b1;
        end
        S_EXEC: begin
          if (stat_i.is_get) begin
            state_q <= S_READ;
            read_q  <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_READ: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // command bundle
  always_comb begin
    cmd_o.load    = start && (state_q == S_IDLE);
    cmd_o.compare = compare_q;
    cmd_o.execute = execute_q;
    cmd_o.read    = read_q;
  end

  assign busy = (state_q != S_IDLE);

endmodule
